FILE: design/chm_pkg.sv
// Package with the constants, types and request codes of the chained hash map engine.
package chm_pkg;

    localparam int BUCKETS_DEF      = 128;
    localparam int POOL_ENTRIES_DEF = 256;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int KEY_W            = 64;
    localparam int OUT_VALUE_W      = 32;
    localparam logic [31:0] HASH_MUL = 32'd5000;

    localparam logic [1:0] REQ_GET   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_ERASE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] position_key;
        logic [31:0]      cell_value;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [OUT_VALUE_W-1:0] stored_value;
    } t_rsp;

endpackage

FILE: design/chm_if.sv
// Valid/ready channel interfaces for requests and responses.
interface chm_req_if;
    import chm_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface chm_rsp_if;
    import chm_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/chm_hash.sv
// Bucket index unit: pipelined 32x32 multiply and add, then a reciprocal reduction.
module chm_hash #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                      i_clk,
    input  logic [chm_pkg::KEY_W-1:0] i_key,
    output logic [BW-1:0]             o_bucket
);
    import chm_pkg::*;

    // The quotient comes from a multiply by a rounded-up reciprocal, which is exact
    // for every 32-bit sum; the index is registered through the product, sum and quotient stages.
    localparam int            SH    = 32 + BW;
    localparam logic [63:0]   RECIP = ((64'd1 << SH) / 64'(BUCKETS)) + 64'd1;
    localparam logic [BW-1:0] D_LOW = BW'(BUCKETS);

    logic [31:0]   r_prod;
    logic [31:0]   r_x;
    logic [31:0]   r_sum;
    logic [BW-1:0] r_sum_d;
    logic [BW-1:0] r_q;
    logic [64:0]   w_mul;

    assign w_mul = 65'(r_sum) * 65'(RECIP[32:0]);

    always_ff @(posedge i_clk) begin
        r_prod  <= 32'(HASH_MUL * i_key[63:32]);
        r_x     <= i_key[31:0];
        r_sum   <= r_x + r_prod;
        r_q     <= BW'(w_mul >> SH);
        r_sum_d <= r_sum[BW-1:0];
    end

    // The remainder is below BUCKETS, so only its low bits are needed.
    assign o_bucket = r_sum_d - BW'(r_q * D_LOW);
endmodule

FILE: design/chained_hash_map_engine.sv
// Top level: a sequencer walks one bucket chain in the entry memories per request.
// Requests are taken only in idle, so a new request waits until the current one has
// passed through the hash, walk, stack pop, link and output states; the response
// register frees the sequencer, which waits only while an older response is held.
// Reset: synchronous active low; clears control state and head valid bits, fills the free stack lazily.
module chained_hash_map_engine #(
    parameter int BUCKETS      = chm_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF,
    parameter int VALUE_WIDTH  = chm_pkg::VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp
);
    import chm_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int LW = PW + 1;               // index with null marker
    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
    localparam logic [CW-1:0] FULL_CNT = CW'(POOL_ENTRIES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH1 = 4'd1;
    localparam logic [3:0] S_HASH2 = 4'd2;
    localparam logic [3:0] S_HASH3 = 4'd3;
    localparam logic [3:0] S_HEAD  = 4'd4;
    localparam logic [3:0] S_LOAD  = 4'd5;
    localparam logic [3:0] S_READ  = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_POP   = 4'd8;
    localparam logic [3:0] S_LINK  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state, n_state;

    // memories
    logic [LW-1:0]          m_head [BUCKETS];
    logic [BUCKETS-1:0]     r_head_vld;
    logic [KEY_W-1:0]       m_key  [POOL_ENTRIES];
    logic [VALUE_WIDTH-1:0] m_val  [POOL_ENTRIES];
    logic [LW-1:0]          m_link [POOL_ENTRIES];
    logic [LW-1:0]          m_free [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_free_vld;

    logic [1:0]             r_type;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [BW-1:0]          w_bucket;
    logic [BW-1:0]          r_bucket;
    logic [LW-1:0]          r_cur, r_prev, r_slot;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_steps;
    logic [KEY_W-1:0]       r_rd_key;
    logic [VALUE_WIDTH-1:0] r_rd_val;
    logic [LW-1:0]          r_rd_link;
    logic [LW-1:0]          r_head_rd;
    logic                   r_head_rd_vld;
    logic [LW-1:0]          r_free_rd;
    logic                   r_free_rd_vld;
    logic                   r_ovld;
    logic                   r_found;
    t_rsp                   r_rsp;
    t_rsp                   r_res;
    t_rsp                   w_res;
    logic [CW-1:0]          w_top;
    logic                   w_hit;
    logic                   w_room;
    logic                   w_out_free;

    chm_hash #(.BUCKETS(BUCKETS), .BW(BW)) u_hash (
        .i_clk   (i_clk),
        .i_key   (r_key),
        .o_bucket(w_bucket)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_rsp;
    assign w_top = r_cnt - CW'(1);

    function automatic logic [31:0] ext_val(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign w_hit      = (r_rd_key == r_key);
    assign w_room     = (r_cnt != '0) && (r_slot < NIL);
    assign w_out_free = !r_ovld || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid && i_req.ready) n_state = S_HASH1;
            S_HASH1: n_state = S_HASH2;
            S_HASH2: n_state = S_HASH3;
            S_HASH3: n_state = S_HEAD;
            S_HEAD:  n_state = S_LOAD;
            S_LOAD:  n_state = S_READ;
            S_READ:  n_state = (r_cur >= NIL) ? S_POP : S_CMP;
            S_CMP:   n_state = (w_hit || r_steps == FULL_CNT - CW'(1)) ? S_POP : S_READ;
            S_POP:   n_state = S_LINK;
            S_LINK:  n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Response of the current request, taken once the walk and the stack read are done.
    always_comb begin
        w_res.status       = ST_NOT_FOUND;
        w_res.stored_value = '0;
        unique case (r_type)
            REQ_GET: begin
                if (r_found) begin
                    w_res.status       = ST_OK;
                    w_res.stored_value = ext_val(r_rd_val);
                end
            end
            REQ_SET: begin
                if (r_found || w_room) begin
                    w_res.status       = ST_OK;
                    w_res.stored_value = ext_val(r_val);
                end else begin
                    w_res.status = ST_FULL;
                end
            end
            REQ_ERASE: begin
                if (r_found) w_res.status = ST_OK;
            end
            default: ;
        endcase
    end

    // Walk state; r_cur holds the matching entry when the walk stops on a hit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head_vld <= '0;
            r_free_vld <= '0;
            r_cnt      <= FULL_CNT;
            r_ovld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) r_ovld <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_type <= i_req.data.req_type;
                        r_key  <= i_req.data.position_key;
                        r_val  <= VALUE_WIDTH'(i_req.data.cell_value);
                    end
                end
                S_HEAD: r_bucket <= w_bucket;
                S_LOAD: begin
                    r_cur   <= r_head_rd_vld ? r_head_rd : NIL;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_found <= 1'b0;
                end
                S_CMP: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                    end else if (r_steps != FULL_CNT - CW'(1)) begin
                        r_prev  <= r_cur;
                        r_cur   <= r_rd_link;
                        r_steps <= r_steps + CW'(1);
                    end else begin
                        r_cur <= NIL;
                    end
                end
                S_POP: begin
                    r_slot <= r_free_rd_vld ? r_free_rd
                                            : (LW'(POOL_ENTRIES - 1) - LW'(w_top));
                end
                S_LINK: begin
                    r_res <= w_res;
                    if (r_type == REQ_SET && r_found) begin
                        m_val[PW'(r_cur)] <= r_val;
                    end else if (r_type == REQ_SET && w_room) begin
                        r_cnt <= w_top;
                        m_key[PW'(r_slot)]  <= r_key;
                        m_val[PW'(r_slot)]  <= r_val;
                        m_link[PW'(r_slot)] <= NIL;
                        if (r_prev < NIL) m_link[PW'(r_prev)] <= r_slot;
                        else begin
                            m_head[r_bucket]     <= r_slot;
                            r_head_vld[r_bucket] <= 1'b1;
                        end
                    end else if (r_type == REQ_ERASE && r_found) begin
                        if (r_prev < NIL) m_link[PW'(r_prev)] <= r_rd_link;
                        else begin
                            m_head[r_bucket]     <= r_rd_link;
                            r_head_vld[r_bucket] <= 1'b1;
                        end
                        m_link[PW'(r_cur)] <= NIL;
                        if (r_cnt < FULL_CNT) begin
                            m_free[PW'(r_cnt)]     <= r_cur;
                            r_free_vld[PW'(r_cnt)] <= 1'b1;
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) r_rsp <= r_res;
                end
                default: ;
            endcase
        end
    end

    // Registered memory reads.
    always_ff @(posedge i_clk) begin
        r_head_rd     <= m_head[w_bucket];
        r_head_rd_vld <= r_head_vld[w_bucket];
        r_rd_key      <= m_key[PW'(r_cur)];
        r_rd_val      <= m_val[PW'(r_cur)];
        r_rd_link     <= m_link[PW'(r_cur)];
        // A never-written stack slot i holds its initial index POOL_ENTRIES-1-i.
        r_free_rd     <= m_free[PW'(w_top)];
        r_free_rd_vld <= r_free_vld[PW'(w_top)];
    end

    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT) else $error("free count beyond pool");
    ap_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_ovld) else $error("response not raised");
endmodule
